// File: rtl/sha_pkg.sv
package sha_pkg;

    localparam int WordW = 32;
    localparam int BlockWords = 16;
    localparam int Rounds = 64;
    localparam int LenPos = 56;

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        begin
            case (idx)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        begin
            case (idx)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        begin
            return (x >> n) | (x << (32 - n));
        end
    endfunction

    // Round datapath state, packed for passing between modules.
    typedef struct packed {
        logic [31:0] a, b, c, d, e, f, g, h;
    } t_vars;

endpackage

// File: rtl/sha_round.sv
module sha_round (
    input  logic           i_clk,
    input  logic           i_load,
    input  logic           i_step,
    input  sha_pkg::t_vars i_init,
    input  logic [31:0]    i_w,
    input  logic [5:0]     i_idx,
    output sha_pkg::t_vars o_vars
);

    sha_pkg::t_vars r_v;
    logic [31:0] s1, chv, t1, s0, mj;

    always_comb begin
        s1  = sha_pkg::rotr(r_v.e, 6) ^ sha_pkg::rotr(r_v.e, 11) ^ sha_pkg::rotr(r_v.e, 25);
        chv = (r_v.e & r_v.f) ^ (~r_v.e & r_v.g);
        t1  = r_v.h + s1 + chv + sha_pkg::round_const(i_idx) + i_w;
        s0  = sha_pkg::rotr(r_v.a, 2) ^ sha_pkg::rotr(r_v.a, 13) ^ sha_pkg::rotr(r_v.a, 22);
        mj  = (r_v.a & r_v.b) ^ (r_v.a & r_v.c) ^ (r_v.b & r_v.c);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_v <= i_init;
        end else if (i_step) begin
            r_v.h <= r_v.g;
            r_v.g <= r_v.f;
            r_v.f <= r_v.e;
            r_v.e <= r_v.d + t1;
            r_v.d <= r_v.c;
            r_v.c <= r_v.b;
            r_v.b <= r_v.a;
            r_v.a <= t1 + s0 + mj;
        end
    end

    assign o_vars = r_v;

endmodule

// File: rtl/sha_sched.sv
module sha_sched (
    input  logic        i_clk,
    input  logic        i_wr,
    input  logic [3:0]  i_wr_idx,
    input  logic [31:0] i_wr_data,
    input  logic        i_step,
    input  logic [5:0]  i_idx,
    output logic [31:0] o_w
);

    logic [31:0] r_w [16];
    logic [31:0] x2, x15, g0, g1, exp;
    logic [3:0]  t;

    always_comb begin
        t   = i_idx[3:0];
        x2  = r_w[t - 4'd2];
        x15 = r_w[t - 4'd15];
        g1  = sha_pkg::rotr(x2, 17) ^ sha_pkg::rotr(x2, 19) ^ (x2 >> 10);
        g0  = sha_pkg::rotr(x15, 7) ^ sha_pkg::rotr(x15, 18) ^ (x15 >> 3);
        exp = g1 + r_w[t - 4'd7] + g0 + r_w[t];
        o_w = (i_idx < 6'd16) ? r_w[t] : exp;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_w[i_wr_idx] <= i_wr_data;
        end else if (i_step && i_idx >= 6'd16) begin
            r_w[t] <= exp;
        end
    end

endmodule

// File: rtl/sha256_stream_hasher.sv
// A byte that does not fill a block is absorbed while idle; a block fill adds
// a load step, the rounds of one compression and a chain update step.
// The end of a message pads one word per cycle, runs one or two compressions
// and then offers eight digest words, one per cycle as the consumer takes them.
// With the single shared round unit, new bytes are stalled while it is busy.
// Reset (synchronous, active low) restores the initial hash and a zero count.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_final_word
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  r_state;
    logic [31:0] r_chain [8];
    logic [63:0] r_count;
    logic [5:0]  r_round;
    logic [31:0] r_acc;       // word being assembled from bytes
    logic [3:0]  r_pad_idx;   // next word written during padding
    logic        r_finish;    // padding pending after the current compression
    logic        r_last_blk;  // the compression running is the final one
    logic        r_spill;     // the padding pass is the length-only extra block
    logic [2:0]  r_out_idx;

    sha_pkg::t_vars init_v, vars;
    logic        load, step, wr;
    logic [3:0]  wr_idx;
    logic [31:0] wr_data, sched_w, byte_word;
    logic        accept, new_word, blk_full;
    logic        spill_first;
    logic [1:0]  bpos;
    logic [63:0] bits;

    always_comb begin
        init_v = {r_chain[0], r_chain[1], r_chain[2], r_chain[3],
                  r_chain[4], r_chain[5], r_chain[6], r_chain[7]};
    end

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign bpos = r_count[1:0];
    assign bits = {r_count[60:0], 3'b000};

    // With fewer than 9 free bytes the length does not fit; the first padding
    // pass then carries only the marker and zeros.
    assign spill_first = (r_count[5:0] >= 6'(sha_pkg::LenPos)) && !r_spill;

    // Big-endian placement of the incoming byte into the word under assembly;
    // the first byte of a word clears the rest.
    always_comb begin
        byte_word = (bpos == 2'd0) ? 32'd0 : r_acc;
        case (bpos)
            2'd0: byte_word[31:24] = i_message_byte;
            2'd1: byte_word[23:16] = i_message_byte;
            2'd2: byte_word[15:8]  = i_message_byte;
            default: byte_word[7:0] = i_message_byte;
        endcase
    end

    assign new_word = accept && i_byte_present;
    assign blk_full = new_word && (r_count[5:0] == 6'd63);

    // Schedule store write: every byte writes its partial word so that
    // padding can read nothing but the register copy in r_acc.
    always_comb begin
        wr = 1'b0;
        wr_idx = r_count[5:2];
        wr_data = byte_word;
        if (new_word) begin
            wr = 1'b1;
        end else if (r_state == S_PAD) begin
            wr = 1'b1;
            wr_idx = r_pad_idx;
            if (r_pad_idx == r_count[5:2] && !r_spill) begin
                // Word holding the 0x80 marker after the partial bytes.
                case (bpos)
                    2'd0: wr_data = 32'h80000000;
                    2'd1: wr_data = {r_acc[31:24], 24'h800000};
                    2'd2: wr_data = {r_acc[31:16], 16'h8000};
                    default: wr_data = {r_acc[31:8], 8'h80};
                endcase
            end else if (!spill_first && r_pad_idx == 4'd14) begin
                wr_data = bits[63:32];
            end else if (!spill_first && r_pad_idx == 4'd15) begin
                wr_data = bits[31:0];
            end else begin
                wr_data = 32'd0;
            end
        end
    end

    assign load = (r_state == S_LOAD);
    assign step = (r_state == S_ROUND);

    sha_sched u_sched (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_step    (step),
        .i_idx     (r_round),
        .o_w       (sched_w)
    );

    sha_round u_round (
        .i_clk  (i_clk),
        .i_load (load),
        .i_step (step),
        .i_init (init_v),
        .i_w    (sched_w),
        .i_idx  (r_round),
        .o_vars (vars)
    );

    always_ff @(posedge i_clk) begin
        if (new_word) begin
            r_acc <= byte_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= 64'd0;
            r_round    <= 6'd0;
            r_pad_idx  <= 4'd0;
            r_finish   <= 1'b0;
            r_last_blk <= 1'b0;
            r_spill    <= 1'b0;
            r_out_idx  <= 3'd0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= sha_pkg::init_hash(3'(i));
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_byte_present) begin
                            r_count <= r_count + 64'd1;
                        end
                        r_finish <= i_end_of_message;
                        if (blk_full) begin
                            r_state <= S_LOAD;
                            r_last_blk <= 1'b0;
                        end else if (i_end_of_message) begin
                            r_state <= S_PAD;
                            r_pad_idx <= i_byte_present
                                ? r_count[5:2] + 4'(r_count[1:0] == 2'd3)
                                : r_count[5:2];
                        end
                    end
                end
                S_LOAD: begin
                    r_round <= 6'd0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'(sha_pkg::Rounds - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_chain[0] <= r_chain[0] + vars.a;
                    r_chain[1] <= r_chain[1] + vars.b;
                    r_chain[2] <= r_chain[2] + vars.c;
                    r_chain[3] <= r_chain[3] + vars.d;
                    r_chain[4] <= r_chain[4] + vars.e;
                    r_chain[5] <= r_chain[5] + vars.f;
                    r_chain[6] <= r_chain[6] + vars.g;
                    r_chain[7] <= r_chain[7] + vars.h;
                    if (r_last_blk) begin
                        r_state <= S_OUT;
                        r_out_idx <= 3'd0;
                    end else if (r_finish) begin
                        r_state <= S_PAD;
                        r_pad_idx <= 4'd0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAD: begin
                    r_pad_idx <= r_pad_idx + 4'd1;
                    if (r_pad_idx == 4'd15) begin
                        r_state <= S_LOAD;
                        if (spill_first) begin
                            r_spill <= 1'b1;
                        end else begin
                            r_last_blk <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == 3'd7) begin
                            r_state <= S_IDLE;
                            r_count <= 64'd0;
                            r_last_blk <= 1'b0;
                            r_finish <= 1'b0;
                            r_spill <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_chain[i] <= sha_pkg::init_hash(3'(i));
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Pad block words 14 and 15 get the length only in the final block; in a
    // spill block they are zero. The first pass over a spilled message writes
    // the marker and zeros, the second pass writes only zeros and the length.
    // That distinction is made by r_spill, which is set at the end of the
    // first pass and cleared once the digest has been taken.

    assign o_valid = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_out_idx];
    assign o_word_number = r_out_idx;
    assign o_final_word = (r_out_idx == 3'd7);

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !accept)
        else $error("item accepted while busy");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> ($past(r_round) == 6'd63))
        else $error("compression ended early");
    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && r_out_idx != 3'd7) |=>
            (o_valid && r_out_idx == $past(r_out_idx) + 3'd1))
        else $error("digest words out of order");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_message_byte;
    logic        i_byte_present;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_number;
    logic        o_final_word;

    sha256_stream_hasher u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_message_byte   (i_message_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digest_word    (o_digest_word),
        .o_word_number    (o_word_number),
        .o_final_word     (o_final_word)
    );

    // One expected digest word as it should leave the block.
    typedef struct {
        logic [31:0] digest;
        logic [2:0]  number;
        logic        is_final;
    } t_digest_word;

    t_digest_word pending_digest_words[$];

    // The bench's own copy of the hash state.
    logic [31:0] chain[8];
    logic [31:0] block_buf[16];
    logic [63:0] bytes_absorbed;

    int  error_count;
    int  stall_left = 0;
    bit  stall_enable;
    bit  gaps_enable;

    localparam logic [31:0] H0[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Full 64-round compression of the buffered block into the chaining value.
    task automatic compress_into_chain();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++) w[t] = block_buf[t];
        for (int t = 16; t < 64; t++) begin
            w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10))
                 + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-16];
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & f) ^ (~e & g)) + K[t] + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    // Places one byte big-endian at its position in the block buffer.
    task automatic place_byte(int pos, logic [7:0] b);
        int sh;
        sh = (3 - (pos % 4)) * 8;
        if (pos % 4 == 0) block_buf[pos / 4] = 32'(b) << sh;
        else              block_buf[pos / 4] |= 32'(b) << sh;
    endtask

    task automatic reset_hash_state();
        for (int i = 0; i < 8; i++) chain[i] = H0[i];
        bytes_absorbed = '0;
    endtask

    // Advances the bench's hash state by one accepted word and queues any digest.
    task automatic predict_digest(logic [7:0] b, logic present, logic last);
        int          pos;
        logic [63:0] bit_len;
        t_digest_word dw;
        if (present) begin
            place_byte(int'(bytes_absorbed[5:0]), b);
            bytes_absorbed++;
            if (bytes_absorbed[5:0] == 6'd0) compress_into_chain();
        end
        if (last) begin
            bit_len = bytes_absorbed << 3;
            pos = int'(bytes_absorbed[5:0]);
            place_byte(pos, 8'h80);
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin place_byte(pos, 8'h00); pos++; end
                compress_into_chain();
                pos = 0;
            end
            while (pos < 56) begin place_byte(pos, 8'h00); pos++; end
            block_buf[14] = bit_len[63:32];
            block_buf[15] = bit_len[31:0];
            compress_into_chain();
            for (int k = 0; k < 8; k++) begin
                dw.digest   = chain[k];
                dw.number   = 3'(k);
                dw.is_final = (k == 7);
                pending_digest_words = {pending_digest_words, dw};
            end
            reset_hash_state();
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Offers one word to the block after an optional random gap and
    // holds it steady until it is taken. Valid is left high afterwards so
    // that words can follow back to back.
    task automatic send_word(logic [7:0] b, logic present, logic last);
        int gap;
        gap = gaps_enable ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_message_byte   <= b;
        i_byte_present   <= present;
        i_end_of_message <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_digest(b, present, last);
    endtask

    // Sends a whole message of random bytes; the end mark either rides on the
    // last byte or follows on its own.
    task automatic send_message(int len);
        bit split_end;
        split_end = (len == 0) || $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom), 1'b1, (i == len - 1) && !split_end);
        if (split_end) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Consumer side: a random wait after each word, compare at acceptance.
    always @(posedge i_clk) begin
        t_digest_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_digest_words.size() == 0) begin
                report_mismatch("unexpected digest word", o_digest_word, '0);
            end else begin
                want = pending_digest_words.pop_front();
                if (o_digest_word !== want.digest)
                    report_mismatch("digest_word", o_digest_word, want.digest);
                if (o_word_number !== want.number)
                    report_mismatch("word_number", 32'(o_word_number), 32'(want.number));
                if (o_final_word !== want.is_final)
                    report_mismatch("final_word", 32'(o_final_word), 32'(want.is_final));
            end
            stall_left = stall_enable ? $urandom_range(0, 16) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_stall <= (stall_left != 0);
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_digest_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Directed: empty message, single bytes at both extremes, words with
    // neither flag, and a short message with ignored words inside it.
    task automatic test_directed();
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        wait_drained();
    endtask

    // A 56-byte message needs the extra length block; a 64-byte message ends
    // exactly on a block edge.
    task automatic test_padding_boundaries();
        int lens[2] = '{56, 64};
        foreach (lens[i]) send_message(lens[i]);
        wait_drained();
    endtask

    // Random short messages with full idling on both sides, then a stretch
    // without any idling, with the odd ignored word mixed in.
    task automatic test_random_messages();
        int sent;
        sent = 0;
        while (sent < 30) begin
            int len;
            if (sent > 15) begin gaps_enable = 0; stall_enable = 0; end
            if ($urandom_range(0, 7) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20)
                                              : $urandom_range(0, 12);
            send_message(len);
            sent += len + 1;
        end
        wait_drained();
    endtask

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_message_byte = '0;
        i_byte_present = 0;
        i_end_of_message = 0;
        i_stall = 0;
        error_count = 0;
        stall_enable = 1;
        gaps_enable = 1;
        reset_hash_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_padding_boundaries();
        test_random_messages();

        if (error_count == 0) $display("** sha256_stream_hasher: PASSED **");
        else $display("** sha256_stream_hasher: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout waiting for the block");
        $display("** sha256_stream_hasher: FAILED **");
        $finish;
    end

endmodule
